// ===== design/iee_pkg.sv =====
package iee_pkg;

    localparam int OP_STACK_DEPTH    = 16;
    localparam int VALUE_STACK_DEPTH = 16;
    localparam int OP_AW  = (OP_STACK_DEPTH > 1) ? $clog2(OP_STACK_DEPTH) : 1;
    localparam int VAL_AW = (VALUE_STACK_DEPTH > 1) ? $clog2(VALUE_STACK_DEPTH) : 1;
    localparam int OP_CW  = $clog2(OP_STACK_DEPTH + 1);
    localparam int VAL_CW = $clog2(VALUE_STACK_DEPTH + 1);

    typedef logic [2:0] t_opc;
    localparam t_opc OPC_ADD  = 3'd0;
    localparam t_opc OPC_SUB  = 3'd1;
    localparam t_opc OPC_MUL  = 3'd2;
    localparam t_opc OPC_DIV  = 3'd3;
    localparam t_opc OPC_LPAR = 3'd4;
    localparam t_opc OPC_RPAR = 3'd5;

    typedef logic [2:0] t_err;
    localparam t_err ERR_NONE     = 3'd0;
    localparam t_err ERR_PAREN    = 3'd1;
    localparam t_err ERR_OPERAND  = 3'd2;
    localparam t_err ERR_DIVZERO  = 3'd3;
    localparam t_err ERR_OVERFLOW = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_POP_RD, ST_POP_CHK, ST_VAL_RD1, ST_VAL_RD2,
        ST_EXEC, ST_DIV, ST_WB, ST_PUSH, ST_DONE
    } t_state;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] x;
        logic [31:0] y;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] q;
    } t_div_rsp;

    function automatic logic is_high(input t_opc op);
        return (op == OPC_MUL) || (op == OPC_DIV);
    endfunction

endpackage

// ===== design/iee_if.sv =====
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_expr;
    modport source (output valid, char_code, end_of_expr, input ready);
    modport sink (input valid, char_code, end_of_expr, output ready);
endinterface

interface iee_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] value;
    logic [2:0]  error_code;
    modport source (output valid, value, error_code, input ready);
    modport sink (input valid, value, error_code, output ready);
endinterface

// ===== design/infix_expression_evaluator_unit.sv =====
// Shunting-yard infix evaluator; operator and value stacks live in two synchronous RAMs.
// Sequence: a digit is accumulated; an operator first pops and applies stacked operators of equal or higher
// precedence, then is pushed; a division waits on the bit-serial divider. The last character adds the drain.
// Throughput: one character at a time; the next character is accepted only in ST_IDLE with no result pending.
// Reset (i_rst_n low, synchronous) clears tops, accumulator and error; RAM contents stay.
module infix_expression_evaluator_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    iee_in_if.sink   i_in,
    iee_out_if.source o_out
);
    import iee_pkg::*;

    t_state      r_state, n_state;
    logic [OP_CW-1:0]  r_op_top, n_op_top;
    logic [VAL_CW-1:0] r_val_top, n_val_top;
    logic [31:0] r_acc, n_acc;
    logic        r_innum, n_innum;
    t_err        r_err, n_err;
    logic [7:0]  r_ch, n_ch;
    logic        r_last, n_last;
    logic        r_flushed, n_flushed;
    t_opc        r_pop, n_pop;
    logic [31:0] r_y, n_y;
    logic [31:0] r_x, n_x;
    logic [31:0] r_res, n_res;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_oval, n_oval;
    t_err        r_oerr, n_oerr;

    logic        w_op_we, w_val_we;
    logic [OP_AW-1:0]  w_op_waddr, w_op_raddr;
    logic [VAL_AW-1:0] w_val_waddr, w_val_raddr;
    t_opc        w_op_wdata, w_op_rdata, w_cur;
    logic [31:0] w_val_wdata, w_val_rdata;
    logic [31:0] w_mul;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    iee_stacks u_stacks (
        .i_clk       (i_clk),
        .i_op_we     (w_op_we),
        .i_op_waddr  (w_op_waddr),
        .i_op_wdata  (w_op_wdata),
        .i_op_raddr  (w_op_raddr),
        .o_op_rdata  (w_op_rdata),
        .i_val_we    (w_val_we),
        .i_val_waddr (w_val_waddr),
        .i_val_wdata (w_val_wdata),
        .i_val_raddr (w_val_raddr),
        .o_val_rdata (w_val_rdata)
    );

    iee_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_mul = r_x * r_y;

    // decode the held character
    always_comb begin
        case (r_ch)
            CH_PLUS:  w_cur = OPC_ADD;
            CH_MINUS: w_cur = OPC_SUB;
            CH_STAR:  w_cur = OPC_MUL;
            CH_SLASH: w_cur = OPC_DIV;
            CH_LPAR:  w_cur = OPC_LPAR;
            default:  w_cur = OPC_RPAR;
        endcase
    end

    assign i_in.ready       = (r_state == ST_IDLE) && !r_ovalid;
    assign o_out.valid      = r_ovalid;
    assign o_out.value      = r_oval;
    assign o_out.error_code = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op_top  <= '0;
            r_val_top <= '0;
            r_acc     <= '0;
            r_innum   <= 1'b0;
            r_err     <= ERR_NONE;
            r_ovalid  <= 1'b0;
            r_flushed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op_top  <= n_op_top;
            r_val_top <= n_val_top;
            r_acc     <= n_acc;
            r_innum   <= n_innum;
            r_err     <= n_err;
            r_ovalid  <= n_ovalid;
            r_flushed <= n_flushed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_last <= n_last;
        r_pop  <= n_pop;
        r_x    <= n_x;
        r_y    <= n_y;
        r_res  <= n_res;
        r_oval <= n_oval;
        r_oerr <= n_oerr;
    end

    // sequencer: classify, pop/apply, push, drain at end
    always_comb begin
        n_state = r_state;   n_op_top = r_op_top;  n_val_top = r_val_top;
        n_acc = r_acc;       n_innum = r_innum;    n_err = r_err;
        n_ch = r_ch;         n_last = r_last;      n_flushed = r_flushed;
        n_pop = r_pop;       n_x = r_x;            n_y = r_y;
        n_res = r_res;       n_ovalid = r_ovalid;  n_oval = r_oval;  n_oerr = r_oerr;
        w_op_we = 1'b0;  w_op_waddr = r_op_top[OP_AW-1:0];  w_op_wdata = w_cur;
        w_op_raddr = r_op_top[OP_AW-1:0] - OP_AW'(1);
        w_val_we = 1'b0; w_val_waddr = r_val_top[VAL_AW-1:0]; w_val_wdata = r_acc;
        w_val_raddr = r_val_top[VAL_AW-1:0] - VAL_AW'(1);
        w_dreq.start = 1'b0; w_dreq.x = r_x; w_dreq.y = r_y;

        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_ch = i_in.char_code;
                    n_last = i_in.end_of_expr;
                    n_flushed = 1'b0;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (r_err != ERR_NONE) begin
                    n_state = r_last ? ST_DONE : ST_IDLE;
                end else if (w_cur == OPC_RPAR && r_ch != CH_RPAR) begin
                    // digit: accumulate
                    n_acc = r_acc * 32'd10 + (32'(r_ch) - 32'(CH_ZERO));
                    n_innum = 1'b1;
                    n_state = r_last ? ST_PUSH : ST_IDLE;
                    n_flushed = 1'b1;
                    if (r_last) begin
                        // flush then drain; ST_ACC re-entered with flushed set pushes the number, then ST_POP_RD drains
                        n_state = ST_ACC;
                        n_ch = CH_RPAR;
                        n_flushed = 1'b1;
                    end
                end else if (r_innum) begin
                    n_innum = 1'b0;
                    n_acc = '0;
                    if (r_val_top >= VAL_CW'(VALUE_STACK_DEPTH)) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_val_we = 1'b1;
                        n_val_top = r_val_top + VAL_CW'(1);
                    end
                end else if (r_flushed && r_last) begin
                    n_state = ST_POP_RD;
                end else if (w_cur == OPC_LPAR) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                // top operator read, or finish
                if (r_op_top == '0) begin
                    if (r_flushed && r_last) begin
                        if (r_val_top != VAL_CW'(1)) begin
                            n_err = ERR_OPERAND;
                            n_state = ST_DONE;
                        end else begin
                            w_val_raddr = '0;
                            n_state = ST_VAL_RD1;
                            n_pop = OPC_LPAR;
                        end
                    end else if (w_cur == OPC_RPAR) begin
                        n_err = ERR_PAREN;
                        n_state = r_last ? ST_DONE : ST_IDLE;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end else begin
                    n_state = ST_POP_CHK;
                end
            end
            ST_POP_CHK: begin
                n_pop = w_op_rdata;
                if (r_flushed && r_last) begin
                    n_op_top = r_op_top - OP_CW'(1);
                    if (w_op_rdata == OPC_LPAR) begin
                        n_err = ERR_PAREN;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_VAL_RD1;
                    end
                end else if (w_cur == OPC_RPAR) begin
                    n_op_top = r_op_top - OP_CW'(1);
                    n_state = (w_op_rdata == OPC_LPAR) ? (r_last ? ST_ACC : ST_IDLE)
                                                       : ST_VAL_RD1;
                    if (w_op_rdata == OPC_LPAR && r_last) n_flushed = 1'b1;
                end else if (w_op_rdata == OPC_LPAR ||
                             (!is_high(w_op_rdata) && is_high(w_cur))) begin
                    n_state = ST_PUSH;
                end else begin
                    n_op_top = r_op_top - OP_CW'(1);
                    n_state = ST_VAL_RD1;
                end
            end
            ST_VAL_RD1: begin
                if (r_pop == OPC_LPAR) begin
                    // final value read issued at slot 0
                    n_oval = w_val_rdata;
                    n_state = ST_DONE;
                end else if (r_val_top < VAL_CW'(2)) begin
                    n_err = ERR_OPERAND;
                    n_state = r_last ? ST_DONE : ST_IDLE;
                end else begin
                    // right operand read at top - 1
                    n_state = ST_VAL_RD2;
                end
            end
            ST_VAL_RD2: begin
                n_y = w_val_rdata;
                w_val_raddr = r_val_top[VAL_AW-1:0] - VAL_AW'(2);
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_x = w_val_rdata;
                n_state = ST_WB;
                case (r_pop)
                    OPC_ADD: n_res = w_val_rdata + r_y;
                    OPC_SUB: n_res = w_val_rdata - r_y;
                    OPC_MUL: n_state = ST_WB;
                    default: begin
                        if (r_y == '0) begin
                            n_err = ERR_DIVZERO;
                            n_state = r_last ? ST_DONE : ST_IDLE;
                        end else begin
                            w_dreq.start = 1'b1;
                            w_dreq.x = w_val_rdata;
                            n_state = ST_DIV;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (w_drsp.done) begin
                    n_res = w_drsp.q;
                    n_pop = OPC_ADD;
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                // two popped, one pushed: never overflows
                w_val_we = 1'b1;
                w_val_waddr = r_val_top[VAL_AW-1:0] - VAL_AW'(2);
                w_val_wdata = (r_pop == OPC_MUL) ? w_mul : r_res;
                n_val_top = r_val_top - VAL_CW'(1);
                n_state = ST_POP_RD;
            end
            ST_PUSH: begin
                if (r_op_top >= OP_CW'(OP_STACK_DEPTH)) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    w_op_we = 1'b1;
                    n_op_top = r_op_top + OP_CW'(1);
                end
                n_state = r_last ? ST_ACC : ST_IDLE;
                n_flushed = r_last;
            end
            ST_DONE: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_oerr = r_err;
                    if (r_err != ERR_NONE || r_pop != OPC_LPAR) n_oval = '0;
                    n_op_top = '0;
                    n_val_top = '0;
                    n_acc = '0;
                    n_innum = 1'b0;
                    n_err = ERR_NONE;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== design/iee_div.sv =====
module iee_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iee_pkg::t_div_req i_req,
    output iee_pkg::t_div_rsp o_rsp
);
    import iee_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_try;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_try = {r_rem, r_quo[31]} - {1'b0, r_den};
        if (!w_try[32]) begin
            n_rem = w_try[31:0];
            n_quo = {r_quo[30:0], 1'b1};
        end else begin
            n_rem = {r_rem[30:0], r_quo[31]};
            n_quo = {r_quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.x[31] ? (32'd0 - i_req.x) : i_req.x;
            r_den <= i_req.y[31] ? (32'd0 - i_req.y) : i_req.y;
            r_neg <= i_req.x[31] ^ i_req.y[31];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_neg ? (32'd0 - r_quo) : r_quo;
endmodule

// ===== design/iee_stacks.sv =====
module iee_stacks (
    input  logic                 i_clk,
    input  logic                 i_op_we,
    input  logic [iee_pkg::OP_AW-1:0]  i_op_waddr,
    input  iee_pkg::t_opc        i_op_wdata,
    input  logic [iee_pkg::OP_AW-1:0]  i_op_raddr,
    output iee_pkg::t_opc        o_op_rdata,
    input  logic                 i_val_we,
    input  logic [iee_pkg::VAL_AW-1:0] i_val_waddr,
    input  logic [31:0]          i_val_wdata,
    input  logic [iee_pkg::VAL_AW-1:0] i_val_raddr,
    output logic [31:0]          o_val_rdata
);
    import iee_pkg::*;

    t_opc        r_op_mem [OP_STACK_DEPTH];
    logic [31:0] r_val_mem [VALUE_STACK_DEPTH];

    // synchronous memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_op_we) r_op_mem[i_op_waddr] <= i_op_wdata;
        o_op_rdata <= r_op_mem[i_op_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_val_we) r_val_mem[i_val_waddr] <= i_val_wdata;
        o_val_rdata <= r_val_mem[i_val_raddr];
    end
endmodule

// ===== design/iee_checker.sv =====
module iee_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       o_valid,
    input logic       o_ready,
    input logic [31:0] o_value,
    input logic [2:0] o_error_code
);
    import iee_pkg::*;

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_code <= ERR_OVERFLOW)) else $error("bad error code");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_NONE) |-> (o_value == 32'd0))
        else $error("value on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> (o_valid && $stable(o_value))) else $error("result dropped");
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !i_ready) else $error("input taken with result pending");
endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_valid(i_in.valid), .i_ready(i_in.ready),
    .o_valid(o_out.valid), .o_ready(o_out.ready),
    .o_value(o_out.value), .o_error_code(o_out.error_code)
);
